@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, switched off while reset is high.
`define LCDNW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds through reset.
`define LCDNW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/lcdnw_pkg.sv @@
// Shared types, codes and command tables of the character-LCD write sequencer.
package lcdnw_pkg;

  // action codes carried by an input item
  localparam logic [2:0] ACT_INIT   = 3'd0;
  localparam logic [2:0] ACT_CMD    = 3'd1;
  localparam logic [2:0] ACT_DATA   = 3'd2;
  localparam logic [2:0] ACT_CURSOR = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;
  localparam logic [2:0] ACT_NUMBER = 3'd5;

  // configuration register indexes
  localparam logic CFG_SETUP = 1'b0;
  localparam logic CFG_PULSE = 1'b1;

  localparam logic [15:0] SETUP_RESET = 16'd1000;
  localparam logic [15:0] PULSE_RESET = 16'd2000;

  // display controller command bytes
  localparam logic [7:0] CMD_HOME_4BIT  = 8'h02;
  localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] LINE1_BASE     = 8'h80;
  localparam logic [7:0] LINE2_BASE     = 8'hC0;
  localparam logic [7:0] ASCII_ZERO     = 8'h30;

  localparam logic [2:0] INIT_LAST = 3'd4;

  // number conversion: one input bit per cycle
  localparam int NUM_W = 31;
  localparam logic [4:0] CONV_LAST = 5'(NUM_W - 1);

  // byte queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       last;
    logic       settle;
  } byte_cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_INIT,
    F_CONV,
    F_DIGITS
  } front_state_t;

  typedef enum logic [2:0] {
    S_RS_SETUP,
    S_HI_STROBE,
    S_LO_DRIVE,
    S_LO_STROBE,
    S_LO_RELEASE
  } snap_step_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = CMD_HOME_4BIT;
      3'd1:    b = CMD_FUNC_SET;
      3'd2:    b = CMD_DISP_ON;
      3'd3:    b = CMD_ENTRY_MODE;
      default: b = CMD_CLEAR;
    endcase
    return b;
  endfunction

endpackage

@@ hw/rtl/lcdnw_front.sv @@
// Front end: accepts action items and breaks them into byte commands.
module lcdnw_front #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           action,
  input  logic [7:0]           byte_value,
  input  logic [1:0]           row,
  input  logic [5:0]           column,
  input  logic [30:0]          number,
  output logic                 push_valid,
  output lcdnw_pkg::byte_cmd_t push_cmd,
  input  logic                 q_full
);
  import lcdnw_pkg::*;

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(MAX_DIGITS - 1);

  front_state_t     state, state_next;
  logic [2:0]       init_cnt;
  logic [3:0]       bcd      [MAX_DIGITS];
  logic [3:0]       adj      [MAX_DIGITS];
  logic [3:0]       bcd_next [MAX_DIGITS];
  logic [NUM_W-1:0] bin;
  logic [4:0]       bit_cnt;
  logic [IDX_W-1:0] idx;
  logic             started;
  logic             accept;
  logic [3:0]       cur_digit;
  logic             skip;

  assign accept    = in_valid && in_ready;
  assign cur_digit = bcd[idx];
  // drop leading zeros, but always keep the units digit
  assign skip      = !started && (cur_digit == 4'd0) && (idx != '0);

  // shift-and-add-3 step: BCD digits of five or more are corrected before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
    bcd_next[0] = {adj[0][2:0], bin[NUM_W-1]};
    for (int i = 1; i < MAX_DIGITS; i++) begin
      bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept && action == ACT_INIT) begin
          state_next = F_INIT;
        end else if (accept && action == ACT_NUMBER) begin
          state_next = F_CONV;
        end
      end
      F_INIT: begin
        if (!q_full && init_cnt == INIT_LAST) begin
          state_next = F_IDLE;
        end
      end
      F_CONV: begin
        if (bit_cnt == CONV_LAST) begin
          state_next = F_DIGITS;
        end
      end
      F_DIGITS: begin
        if (!skip && !q_full && idx == '0) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    push_valid = 1'b0;
    push_cmd   = '0;
    case (state)
      F_IDLE: begin
        in_ready        = !q_full;
        push_valid      = accept && (action inside {ACT_CMD, ACT_DATA, ACT_CURSOR, ACT_CLEAR});
        push_cmd.rs     = (action == ACT_DATA);
        push_cmd.last   = 1'b1;
        push_cmd.settle = (action == ACT_CLEAR);
        case (action)
          ACT_CURSOR: push_cmd.data = ((row == 2'd1) ? LINE1_BASE : LINE2_BASE)
                                      + {2'b00, column};
          ACT_CLEAR:  push_cmd.data = CMD_CLEAR;
          default:    push_cmd.data = byte_value;
        endcase
      end
      F_INIT: begin
        push_valid      = !q_full;
        push_cmd.data   = init_byte(init_cnt);
        push_cmd.last   = (init_cnt == INIT_LAST);
        push_cmd.settle = (init_cnt == INIT_LAST);
      end
      F_DIGITS: begin
        push_valid    = !q_full && !skip;
        push_cmd.rs   = 1'b1;
        push_cmd.data = ASCII_ZERO | {4'h0, cur_digit};
        push_cmd.last = (idx == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (accept) begin
          init_cnt <= 3'd0;
          bin      <= number;
          bit_cnt  <= 5'd0;
          started  <= 1'b0;
          for (int i = 0; i < MAX_DIGITS; i++) begin
            bcd[i] <= 4'd0;
          end
        end
      end
      F_INIT: begin
        if (push_valid) begin
          init_cnt <= init_cnt + 3'd1;
        end
      end
      F_CONV: begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
          bcd[i] <= bcd_next[i];
        end
        bin     <= {bin[NUM_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + 5'd1;
        idx     <= TOP_IDX;
        // a carry out of the top digit means the number is wider than the
        // digit field: keep every digit held, zeros included
        if (adj[MAX_DIGITS-1][3]) begin
          started <= 1'b1;
        end
      end
      F_DIGITS: begin
        if (skip) begin
          idx <= idx - 1'b1;
        end else if (push_valid) begin
          started <= 1'b1;
          if (idx != '0) begin
            idx <= idx - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/lcdnw_queue.sv @@
// Short byte-command queue between the front and back ends.
module lcdnw_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lcdnw_pkg::byte_cmd_t push_cmd,
  input  logic                 pop,
  output lcdnw_pkg::byte_cmd_t head,
  output logic                 empty,
  output logic                 full
);
  import lcdnw_pkg::*;

  byte_cmd_t   mem [Q_DEPTH];
  logic [Q_AW:0] wr_ptr;
  logic [Q_AW:0] rd_ptr;

  assign empty = (wr_ptr == rd_ptr);
  assign full  = (wr_ptr[Q_AW] != rd_ptr[Q_AW]) &&
                 (wr_ptr[Q_AW-1:0] == rd_ptr[Q_AW-1:0]);
  assign head  = mem[rd_ptr[Q_AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr[Q_AW-1:0]] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/lcdnw_back.sv @@
// Back end: expands each byte command into five timed pin snapshots.
module lcdnw_back (
  input  logic                 clk,
  input  logic                 rst,
  input  lcdnw_pkg::byte_cmd_t head,
  input  logic                 q_empty,
  output logic                 pop,
  input  logic [15:0]          setup_ticks,
  input  logic [15:0]          pulse_ticks,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 rs_level,
  output logic                 en_level,
  output logic [3:0]           nibble,
  output logic [15:0]          hold_ticks,
  output logic                 last
);
  import lcdnw_pkg::*;

  byte_cmd_t  cur;
  logic       cur_valid;
  snap_step_t step, step_next;
  logic [3:0] nibble_pins;
  logic       advance;
  logic       snap_en;
  logic [3:0] snap_nib;
  logic [15:0] snap_hold;
  logic       snap_last;

  assign advance = cur_valid && (!out_valid || out_ready);
  assign pop     = !cur_valid && !q_empty;

  always_comb begin
    step_next = step;
    if (advance) begin
      case (step)
        S_RS_SETUP:   step_next = S_HI_STROBE;
        S_HI_STROBE:  step_next = S_LO_DRIVE;
        S_LO_DRIVE:   step_next = S_LO_STROBE;
        S_LO_STROBE:  step_next = S_LO_RELEASE;
        default:      step_next = S_RS_SETUP;
      endcase
    end
  end

  always_comb begin
    snap_en   = 1'b0;
    snap_nib  = cur.data[3:0];
    snap_hold = 16'd0;
    snap_last = 1'b0;
    case (step)
      S_RS_SETUP: begin
        snap_nib  = nibble_pins;
        snap_hold = setup_ticks;
      end
      S_HI_STROBE: begin
        snap_en   = 1'b1;
        snap_nib  = cur.data[7:4];
        snap_hold = pulse_ticks;
      end
      S_LO_DRIVE: ;
      S_LO_STROBE: begin
        snap_en   = 1'b1;
        snap_hold = pulse_ticks;
      end
      S_LO_RELEASE: begin
        snap_hold = cur.settle ? pulse_ticks : 16'd0;
        snap_last = cur.last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= S_RS_SETUP;
      cur_valid   <= 1'b0;
      out_valid   <= 1'b0;
      nibble_pins <= 4'd0;
    end else begin
      step <= step_next;
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (advance && step == S_LO_RELEASE) begin
        cur_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance && step == S_LO_RELEASE) begin
        nibble_pins <= cur.data[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (advance) begin
      rs_level   <= cur.rs;
      en_level   <= snap_en;
      nibble     <= snap_nib;
      hold_ticks <= snap_hold;
      last       <= snap_last;
    end
  end

endmodule

@@ hw/rtl/char_lcd_nibble_write_sequencer_top.sv @@
// Top level of the character-LCD 4-bit write sequencer.
// Each accepted item asks for one display action (init, command byte, data
// byte, set cursor, clear, print a decimal number); the block answers with a
// stream of pin snapshots (rs, en, D7..D4, hold time, last flag), five per
// byte sent: register select with setup hold, high nibble strobe, low nibble,
// low nibble strobe, release. The front end takes an item whenever it is
// idle and the byte queue has room; it queues one byte for a plain command,
// data or cursor item at once, walks the five init bytes one a cycle while
// the queue has room, and converts a number with a shift-and-add-3 unit, one
// input bit a cycle, then queues one digit a cycle while the queue has room
// after dropping leading zeros.
// The back end emits one snapshot a cycle while the output is taken and
// pauses to load each byte from the queue before its first snapshot. The
// back-end snapshot sequencer sets the rate; output stalls hold it.
// Configuration writes are always taken and must only happen while the
// block is idle. Unused action codes are taken and produce no snapshots.
module char_lcd_nibble_write_sequencer_top #(
  parameter int MAX_DIGITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  // action items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [7:0]  byte_value,
  input  logic [1:0]  row,
  input  logic [5:0]  column,
  input  logic [30:0] number,
  // pin snapshots
  output logic        out_valid,
  input  logic        out_ready,
  output logic        rs_level,
  output logic        en_level,
  output logic [3:0]  nibble,
  output logic [15:0] hold_ticks,
  output logic        last,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import lcdnw_pkg::*;

  logic [15:0] setup_ticks;
  logic [15:0] pulse_ticks;

  logic      push_valid;
  byte_cmd_t push_cmd;
  byte_cmd_t head;
  logic      q_empty;
  logic      q_full;
  logic      pop;

  // registers never stall the writer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      setup_ticks <= SETUP_RESET;
      pulse_ticks <= PULSE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SETUP: setup_ticks <= cfg_data;
        CFG_PULSE: pulse_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify items and break them into bytes
  lcdnw_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .byte_value (byte_value),
    .row        (row),
    .column     (column),
    .number     (number),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .q_full     (q_full)
  );

  // decouple byte production from snapshot output
  lcdnw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push_valid),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // turn each byte into five snapshots
  lcdnw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .setup_ticks (setup_ticks),
    .pulse_ticks (pulse_ticks),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .rs_level    (rs_level),
    .en_level    (en_level),
    .nibble      (nibble),
    .hold_ticks  (hold_ticks),
    .last        (last)
  );

endmodule

@@ hw/rtl/lcdnw_checker.sv @@
// Port-level checker for the write sequencer, bound to the top level.
`include "assert_macros.svh"

module lcdnw_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        rs_level,
  input logic        en_level,
  input logic [3:0]  nibble,
  input logic [15:0] hold_ticks,
  input logic        last
);

  // hold a stalled snapshot unchanged
  `LCDNW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(rs_level) && $stable(en_level) && $stable(nibble) && $stable(hold_ticks) && $stable(last), "stalled snapshot changed")

  // drop output valid after reset
  `LCDNW_ASSERT_RST(a_rst_quiet, rst |=> !out_valid, "output valid after reset")

  // final snapshot always releases the strobe
  `LCDNW_ASSERT(a_last_en_low, out_valid && last |-> !en_level, "last snapshot with strobe high")

  // a taken strobe-high snapshot is followed by a strobe-low one
  `LCDNW_ASSERT(a_strobe_fall, out_valid && out_ready && en_level |=> !(out_valid && en_level), "strobe high twice in a row")

endmodule

bind char_lcd_nibble_write_sequencer_top lcdnw_checker u_lcdnw_checker (.*);

@@ verif/char_lcd_nibble_write_sequencer_top_tb.sv @@
// Self-checking testbench for the character-LCD 4-bit write sequencer.
module char_lcd_nibble_write_sequencer_top_tb;
  import lcdnw_pkg::*;

  localparam int MAX_DIGITS = 10;
  // action codes the block takes but answers with nothing
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  // cycles to let pass once the last expected snapshot is in, so that any
  // work on a silent item can finish too
  localparam int SETTLE_CYCLES = 150;
  // cycles with no handshake on any channel before the run is declared hung
  localparam int HANG_LIMIT = 20000;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 64;

  typedef struct {
    logic [2:0]  action;
    logic [7:0]  byte_value;
    logic [1:0]  row;
    logic [5:0]  column;
    logic [30:0] number;
  } lcd_req_t;

  typedef struct {
    logic        rs;
    logic        en;
    logic [3:0]  nib;
    logic [15:0] hold;
    logic        fin;
  } pin_snap_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  action = '0;
  logic [7:0]  byte_value = '0;
  logic [1:0]  row = '0;
  logic [5:0]  column = '0;
  logic [30:0] number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        rs_level;
  logic        en_level;
  logic [3:0]  nibble;
  logic [15:0] hold_ticks;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_SETUP;
  logic [15:0] cfg_data = '0;

  // stimulus and prediction state
  lcd_req_t    action_backlog[$];
  pin_snap_t   pending_snaps[$];
  logic [15:0] setup_cfg = SETUP_RESET;
  logic [15:0] pulse_cfg = PULSE_RESET;
  logic [3:0]  pin_nibble = '0;
  logic        item_taken = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  char_lcd_nibble_write_sequencer_top #(
    .MAX_DIGITS(MAX_DIGITS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .byte_value (byte_value),
    .row        (row),
    .column     (column),
    .number     (number),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rs_level   (rs_level),
    .en_level   (en_level),
    .nibble     (nibble),
    .hold_ticks (hold_ticks),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Append the five pin snapshots of one byte: register select with setup
  // hold (pins still show the previous low nibble), high nibble strobe,
  // low nibble drive, low nibble strobe, release.
  function automatic void add_byte(input logic rs_sel, input logic [7:0] b);
    pending_snaps.push_back('{rs_sel, 1'b0, pin_nibble, setup_cfg, 1'b0});
    pending_snaps.push_back('{rs_sel, 1'b1, b[7:4], pulse_cfg, 1'b0});
    pending_snaps.push_back('{rs_sel, 1'b0, b[3:0], 16'd0, 1'b0});
    pending_snaps.push_back('{rs_sel, 1'b1, b[3:0], pulse_cfg, 1'b0});
    pending_snaps.push_back('{rs_sel, 1'b0, b[3:0], 16'd0, 1'b0});
    pin_nibble = b[3:0];
  endfunction

  // Work out every snapshot that one accepted item should produce.
  function automatic void predict_snaps(input logic [2:0] act, input logic [7:0] bv,
                                        input logic [1:0] rw, input logic [5:0] col,
                                        input logic [30:0] num);
    logic [7:0]  digit_q[$];
    logic [30:0] rest;
    logic        settle;
    int          first;
    int          k;
    settle = 1'b0;
    first = pending_snaps.size();
    rest = num;
    case (act)
      ACT_INIT: begin
        add_byte(1'b0, CMD_HOME_4BIT);
        add_byte(1'b0, CMD_FUNC_SET);
        add_byte(1'b0, CMD_DISP_ON);
        add_byte(1'b0, CMD_ENTRY_MODE);
        add_byte(1'b0, CMD_CLEAR);
        settle = 1'b1;
      end
      ACT_CMD:    add_byte(1'b0, bv);
      ACT_DATA:   add_byte(1'b1, bv);
      // row 1 is the first line; anything else lands on the second
      ACT_CURSOR: add_byte(1'b0, ((rw == 2'd1) ? LINE1_BASE : LINE2_BASE) + 8'(col));
      ACT_CLEAR: begin
        add_byte(1'b0, CMD_CLEAR);
        settle = 1'b1;
      end
      ACT_NUMBER: begin
        // collect digits least significant first, send most significant first
        do begin
          digit_q.push_front(ASCII_ZERO + 8'(rest % 31'd10));
          rest = rest / 31'd10;
        end while (rest != 0 && digit_q.size() < MAX_DIGITS);
        foreach (digit_q[i]) add_byte(1'b1, digit_q[i]);
      end
      default: ;
    endcase
    if (pending_snaps.size() > first) begin
      k = pending_snaps.size() - 1;
      if (settle) pending_snaps[k].hold = pulse_cfg;
      pending_snaps[k].fin = 1'b1;
    end
  endfunction

  function automatic lcd_req_t make_req(input logic [2:0] act, input logic [7:0] bv,
                                        input logic [1:0] rw, input logic [5:0] col,
                                        input logic [30:0] num);
    lcd_req_t r;
    r.action = act;
    r.byte_value = bv;
    r.row = rw;
    r.column = col;
    r.number = num;
    return r;
  endfunction

  // Random number with weight on short values, decade edges and the top end.
  function automatic logic [30:0] random_number();
    logic [30:0] p;
    p = 31'd1;
    case ($urandom_range(4))
      0: return 31'($urandom_range(9));
      1: return 31'($urandom_range(99999));
      2: return 31'($urandom);
      3: begin
        repeat ($urandom_range(1, 9)) p = p * 31'd10;
        return p - 31'($urandom_range(1));
      end
      default: return 31'h7FFF_FFFF - 31'($urandom_range(99));
    endcase
  endfunction

  // Random item: all fields always random, action weighted towards the
  // cheap byte actions with numbers and init mixed in, spare codes rare.
  function automatic lcd_req_t random_req();
    logic [2:0] act;
    int pick;
    pick = $urandom_range(99);
    if (pick < 8)       act = ACT_INIT;
    else if (pick < 23) act = ACT_CMD;
    else if (pick < 43) act = ACT_DATA;
    else if (pick < 60) act = ACT_CURSOR;
    else if (pick < 68) act = ACT_CLEAR;
    else if (pick < 95) act = ACT_NUMBER;
    else if (pick < 98) act = ACT_SPARE_LO;
    else                act = ACT_SPARE_HI;
    return make_req(act, 8'($urandom), 2'($urandom), 6'($urandom), random_number());
  endfunction

  function automatic void check_field(input string fname, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  // Note acceptance of an item and predict its snapshots at the same edge.
  always @(posedge clk) begin
    item_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready)
      predict_snaps(action, byte_value, row, column, number);
  end

  // Item driver: hold the current item until taken, then load the next one
  // from the backlog unless this cycle is chosen to idle.
  always @(negedge clk) begin
    lcd_req_t nxt;
    if (!rst && (!in_valid || item_taken)) begin
      if (action_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = action_backlog.pop_front();
        in_valid   <= 1'b1;
        action     <= nxt.action;
        byte_value <= nxt.byte_value;
        row        <= nxt.row;
        column     <= nxt.column;
        number     <= nxt.number;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Drive back-pressure on the snapshot channel.
  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // Snapshot monitor: compare each taken snapshot with the oldest one due.
  always @(posedge clk) begin
    pin_snap_t due;
    if (!rst && out_valid && out_ready) begin
      if (pending_snaps.size() == 0) begin
        $display("%0t: snapshot with none due: rs %0h en %0h nibble %0h hold %0h last %0h",
                 $time, rs_level, en_level, nibble, hold_ticks, last);
        mismatches++;
      end else begin
        due = pending_snaps.pop_front();
        check_field("rs_level", 16'(due.rs), 16'(rs_level));
        check_field("en_level", 16'(due.en), 16'(en_level));
        check_field("nibble", 16'(due.nib), 16'(nibble));
        check_field("hold_ticks", due.hold, hold_ticks);
        check_field("last", 16'(due.fin), 16'(last));
      end
    end
  end

  // Hang watchdog: any handshake on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= HANG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SETUP) setup_cfg = val;
    else pulse_cfg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for the backlog to empty and every due snapshot to arrive, then let
  // the block finish any silent item still in flight.
  task automatic drain();
    while (action_backlog.size() != 0 || in_valid || pending_snaps.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int send_plan[PHASES];
    int recv_plan[PHASES];
    logic [15:0] setup_plan[PHASES];
    logic [15:0] pulse_plan[PHASES];
    lcd_req_t r;
    int counted;

    send_plan  = '{0, 72, 0, 36, 0};
    recv_plan  = '{0, 0, 72, 36, 0};
    setup_plan = '{16'd0, 16'hFFFF, 16'($urandom), 16'hFFFF, 16'($urandom)};
    pulse_plan = '{16'd0, 16'hFFFF, 16'($urandom), 16'd0, 16'($urandom)};

    // hold reset, then drop it on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at reset timing, no idling
    action_backlog.push_back(make_req(ACT_INIT, 8'h00, 2'd1, 6'd0, 31'd0));
    action_backlog.push_back(make_req(ACT_CMD, 8'h00, 2'd0, 6'd0, 31'd0));
    action_backlog.push_back(make_req(ACT_CMD, 8'hFF, 2'd3, 6'd63, 31'h7FFF_FFFF));
    action_backlog.push_back(make_req(ACT_DATA, 8'h00, 2'd2, 6'd17, 31'd5));
    action_backlog.push_back(make_req(ACT_DATA, 8'hFF, 2'd1, 6'd0, 31'd0));
    action_backlog.push_back(make_req(ACT_DATA, 8'hA5, 2'd0, 6'd0, 31'd0));
    action_backlog.push_back(make_req(ACT_CURSOR, 8'h00, 2'd1, 6'd0, 31'd0));
    action_backlog.push_back(make_req(ACT_CURSOR, 8'hFF, 2'd1, 6'd63, 31'd0));
    action_backlog.push_back(make_req(ACT_CURSOR, 8'h00, 2'd2, 6'd0, 31'd0));
    action_backlog.push_back(make_req(ACT_CURSOR, 8'h00, 2'd2, 6'd63, 31'd0));
    // rows outside 1 and 2 fall back to the second line
    action_backlog.push_back(make_req(ACT_CURSOR, 8'h00, 2'd0, 6'd5, 31'd0));
    action_backlog.push_back(make_req(ACT_CURSOR, 8'h00, 2'd3, 6'd40, 31'd0));
    action_backlog.push_back(make_req(ACT_CLEAR, 8'h5A, 2'd2, 6'd9, 31'd77));
    // zero prints a single digit; decade edges and the widest value
    action_backlog.push_back(make_req(ACT_NUMBER, 8'h00, 2'd1, 6'd0, 31'd0));
    action_backlog.push_back(make_req(ACT_NUMBER, 8'h00, 2'd1, 6'd0, 31'd9));
    action_backlog.push_back(make_req(ACT_NUMBER, 8'h00, 2'd1, 6'd0, 31'd10));
    action_backlog.push_back(make_req(ACT_NUMBER, 8'h00, 2'd1, 6'd0, 31'd999999999));
    action_backlog.push_back(make_req(ACT_NUMBER, 8'h00, 2'd1, 6'd0, 31'd1000000000));
    action_backlog.push_back(make_req(ACT_NUMBER, 8'hFF, 2'd3, 6'd63, 31'h7FFF_FFFF));
    // spare codes must pass silently and leave the pins alone
    action_backlog.push_back(make_req(ACT_SPARE_LO, 8'hFF, 2'd3, 6'd63, 31'h7FFF_FFFF));
    action_backlog.push_back(make_req(ACT_SPARE_HI, 8'h00, 2'd0, 6'd0, 31'd0));
    action_backlog.push_back(make_req(ACT_DATA, 8'h3C, 2'd0, 6'd0, 31'd0));
    action_backlog.push_back(make_req(ACT_CLEAR, 8'h00, 2'd1, 6'd0, 31'd0));

    // random phases: retime the block while idle, then vary the idling
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_reg(CFG_SETUP, setup_plan[ph]);
      write_reg(CFG_PULSE, pulse_plan[ph]);
      send_idle_pct  = send_plan[ph];
      recv_stall_pct = recv_plan[ph];
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        r = random_req();
        if (r.action <= ACT_NUMBER) counted++;
        action_backlog.push_back(r);
      end
    end

    drain();
    if (mismatches == 0 && pending_snaps.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
